@@ rtl/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg
// shared types and codes for the sorted priority queue
// ----------------------------------------------------------------------------
package spq_pkg;

    // command codes carried in s_tuser
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    // result status codes carried in m_tuser
    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    // fixed field widths of the stream payload
    localparam int IN_VALUE_W  = 32;
    localparam int IN_PRIO_W   = 8;
    localparam int OUT_FILL_W  = 5;

    // operation broadcast to every cell for one item
    typedef struct packed {
        logic ins;   // insert that fits
        logic rem;   // remove from a non-empty queue
    } spq_op_t;

endpackage

@@ rtl/spq_cell.sv @@
// ----------------------------------------------------------------------------
// spq_cell
// one slot of the sorted chain: holds an entry, compares it with the new
// priority and takes its own entry, the new entry, or its left or right neighbor's entry
// ----------------------------------------------------------------------------
module spq_cell import spq_pkg::*; #(
    parameter int VALUE_WIDTH    = 32,
    parameter int PRIORITY_WIDTH = 8
) (
    input  logic                      aclk,
    input  spq_op_t                   op,
    input  logic                      occupied,
    input  logic [VALUE_WIDTH-1:0]    new_value,
    input  logic [PRIORITY_WIDTH-1:0] new_prio,
    input  logic                      left_le,
    input  logic [VALUE_WIDTH-1:0]    left_value,
    input  logic [PRIORITY_WIDTH-1:0] left_prio,
    input  logic [VALUE_WIDTH-1:0]    right_value,
    input  logic [PRIORITY_WIDTH-1:0] right_prio,
    output logic                      self_le,
    output logic [VALUE_WIDTH-1:0]    value,
    output logic [PRIORITY_WIDTH-1:0] prio
);

    logic [VALUE_WIDTH-1:0]    value_reg, value_next;
    logic [PRIORITY_WIDTH-1:0] prio_reg, prio_next;

    // entry stays ahead of the new one when the slot is occupied and its priority is not larger
    assign self_le = occupied && (prio_reg <= new_prio);

    // pick the next entry of this slot
    always_comb begin
        value_next = value_reg;
        prio_next  = prio_reg;
        if (op.ins && !self_le) begin
            if (left_le) begin
                value_next = new_value;
                prio_next  = new_prio;
            end else begin
                value_next = left_value;
                prio_next  = left_prio;
            end
        end else if (op.rem) begin
            value_next = right_value;
            prio_next  = right_prio;
        end
    end

    // payload register, no reset
    always_ff @(posedge aclk) begin
        value_reg <= value_next;
        prio_reg  <= prio_next;
    end

    assign value = value_reg;
    assign prio  = prio_reg;

endmodule

@@ rtl/sorted_priority_queue.sv @@
// ----------------------------------------------------------------------------
// sorted_priority_queue
// bounded priority queue kept sorted in a chain of compare-and-shift cells
// ----------------------------------------------------------------------------
// usage:
//   s_ channel carries one command item: s_tuser is the command (insert or
//   remove), s_tdata the value and priority of an inserted entry.
//   m_ channel returns one result item per command: head value and priority
//   for a remove, zeros otherwise, the fill level after the command, and a
//   status code in m_tuser (done, remove on empty, insert on full).
// throughput and timing:
//   one item per cycle while no result is stalled; the result shows in the cycle after the item is taken.
//   every cell compares its priority with the new one and shifts in the same
//   cycle, so the rate is set by that single compare across the cell row.
// reset:
//   aresetn clears the fill count and the result valid flag; stored entries
//   are not cleared and are only read below the fill count.
// stall:
//   while a result waits and m_tready is low, s_tready drops and the queue
//   holds; an item is taken in the cycle the waiting result leaves.
// ----------------------------------------------------------------------------
module sorted_priority_queue import spq_pkg::*; #(
    parameter int CAPACITY       = 16,
    parameter int VALUE_WIDTH    = 32,
    parameter int PRIORITY_WIDTH = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // in_value[31:0], in_priority[39:32]
    input  logic [0:0]  s_tuser,   // cmd[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // out_value[31:0], out_priority[39:32],
                                   // fill_level[44:40], zero[47:45]
    output logic [1:0]  m_tuser    // status[1:0]
);

    localparam int CW = $clog2(CAPACITY + 1);

    // handshake
    logic m_tvalid_reg;
    logic s_accept;
    logic out_free;
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = out_free;
    assign s_accept = s_tvalid && out_free;

    // input fields cut or zero-extended to the stored widths
    logic                      cmd;
    logic [VALUE_WIDTH-1:0]    new_value;
    logic [PRIORITY_WIDTH-1:0] new_prio;
    assign cmd = s_tuser[0];

    genvar b;
    generate
        for (b = 0; b < VALUE_WIDTH; b++) begin : g_in_val
            if (b < IN_VALUE_W) begin : g_bit
                assign new_value[b] = s_tdata[b];
            end else begin : g_zero
                assign new_value[b] = 1'b0;
            end
        end
        for (b = 0; b < PRIORITY_WIDTH; b++) begin : g_in_pri
            if (b < IN_PRIO_W) begin : g_bit
                assign new_prio[b] = s_tdata[IN_VALUE_W + b];
            end else begin : g_zero
                assign new_prio[b] = 1'b0;
            end
        end
    endgenerate

    // fill count and command decode
    logic [CW-1:0] count_reg, count_next;
    logic          is_full, is_empty;
    spq_op_t       op;
    logic [1:0]    status;

    assign is_full  = (count_reg == CW'(CAPACITY));
    assign is_empty = (count_reg == '0);

    always_comb begin
        op         = '0;
        status     = STATUS_DONE;
        count_next = count_reg;
        if (s_accept) begin
            unique case (cmd)
                CMD_INSERT: begin
                    if (is_full) begin
                        status = STATUS_FULL;
                    end else begin
                        op.ins     = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                end
                CMD_REMOVE: begin
                    if (is_empty) begin
                        status = STATUS_EMPTY;
                    end else begin
                        op.rem     = 1'b1;
                        count_next = count_reg - CW'(1);
                    end
                end
                default: status = STATUS_DONE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // chain of cells, slot 0 holds the head
    logic [VALUE_WIDTH-1:0]    cell_value [CAPACITY];
    logic [PRIORITY_WIDTH-1:0] cell_prio  [CAPACITY];
    logic                      cell_le    [CAPACITY];

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++) begin : g_cell
            logic                      l_le;
            logic [VALUE_WIDTH-1:0]    l_value, r_value;
            logic [PRIORITY_WIDTH-1:0] l_prio, r_prio;
            if (i == 0) begin : g_first
                assign l_le    = 1'b1;
                assign l_value = new_value;
                assign l_prio  = new_prio;
            end else begin : g_mid
                assign l_le    = cell_le[i-1];
                assign l_value = cell_value[i-1];
                assign l_prio  = cell_prio[i-1];
            end
            if (i == CAPACITY - 1) begin : g_last
                assign r_value = cell_value[i];
                assign r_prio  = cell_prio[i];
            end else begin : g_inner
                assign r_value = cell_value[i+1];
                assign r_prio  = cell_prio[i+1];
            end
            spq_cell #(
                .VALUE_WIDTH    (VALUE_WIDTH),
                .PRIORITY_WIDTH (PRIORITY_WIDTH)
            ) u_cell (
                .aclk        (aclk),
                .op          (op),
                .occupied    (count_reg > CW'(i)),
                .new_value   (new_value),
                .new_prio    (new_prio),
                .left_le     (l_le),
                .left_value  (l_value),
                .left_prio   (l_prio),
                .right_value (r_value),
                .right_prio  (r_prio),
                .self_le     (cell_le[i]),
                .value       (cell_value[i]),
                .prio        (cell_prio[i])
            );
        end
    endgenerate

    // head entry and next fill count cut or widened to the result fields
    logic [IN_VALUE_W-1:0] head_value;
    logic [IN_PRIO_W-1:0]  head_prio;
    logic [OUT_FILL_W-1:0] fill_next;

    generate
        for (b = 0; b < IN_VALUE_W; b++) begin : g_out_val
            if (b < VALUE_WIDTH) begin : g_bit
                assign head_value[b] = cell_value[0][b];
            end else begin : g_sign
                assign head_value[b] = cell_value[0][VALUE_WIDTH-1];
            end
        end
        for (b = 0; b < IN_PRIO_W; b++) begin : g_out_pri
            if (b < PRIORITY_WIDTH) begin : g_bit
                assign head_prio[b] = cell_prio[0][b];
            end else begin : g_zero
                assign head_prio[b] = 1'b0;
            end
        end
        for (b = 0; b < OUT_FILL_W; b++) begin : g_fill
            if (b < CW) begin : g_bit
                assign fill_next[b] = count_next[b];
            end else begin : g_zero
                assign fill_next[b] = 1'b0;
            end
        end
    endgenerate

    // result register
    logic [IN_VALUE_W-1:0] res_value_reg;
    logic [IN_PRIO_W-1:0]  res_prio_reg;
    logic [OUT_FILL_W-1:0] res_fill_reg;
    logic [1:0]            res_status_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_free) begin
            m_tvalid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            res_value_reg  <= op.rem ? head_value : '0;
            res_prio_reg   <= op.rem ? head_prio  : '0;
            res_fill_reg   <= fill_next;
            res_status_reg <= status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, res_fill_reg, res_prio_reg, res_value_reg};
    assign m_tuser  = res_status_reg;

    // checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("fill count above capacity");

    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && cmd == CMD_INSERT && !is_full) |=>
        count_reg == $past(count_reg) + CW'(1))
        else $error("insert did not grow the queue");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == STATUS_EMPTY) |->
        (res_value_reg == '0 && res_prio_reg == '0 && res_fill_reg == '0))
        else $error("failed remove returned data");

    a_head_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg >= CW'(2)) |-> (cell_prio[0] <= cell_prio[1]))
        else $error("head entries out of order");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(count_reg))
        else $error("queue changed while result stalled");

endmodule
